### src/lnfb_pkg.sv
package lnfb_pkg;
    localparam int NUM_INPUTS  = 6;
    localparam int VALUE_BITS  = 16;
    localparam int ACC_BITS    = 32;
    localparam int DEPTH       = 1 << NUM_INPUTS;
    localparam int ADDR_W      = NUM_INPUTS;
    localparam int POS_W       = 3;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_FWD   = 3'd1,
        CMD_BWD   = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_FWD_RD, S_FWD_WR, S_BWD_RD, S_BWD_WR, S_FLIP_RD, S_MUL, S_PROD,
        S_SHIFT, S_EMIT, S_CLEAR, S_READ_RD, S_READ_OUT, S_WAIT
    } t_state;
endpackage

### src/lut_node_forward_backward.sv
// Result words: forward and read give one word each, backward gives one gradient word
// per input; load, clear and unused commands give no word.
// One word in work at a time (s_axis_tready high only when idle).
// Reset (i_rst_n low, synchronous) runs a clearing pass over all 64 entries of both
// accumulator memories before the first word is accepted; propagate_enable = 1.
module lut_node_forward_backward import lnfb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], input_bits[8:3], event_weight[24:9], gradient_in[56:25],
    // table_index[62:57], table_value[78:63], zero pad
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // node_value[15:0], formed_address[21:16], input_position[24:22],
    // gradient_out[56:25], hit_sum[88:57], gradient_sum[120:89], zero pad
    output logic [127:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    // Unpacked input word fields
    logic [2:0]            w_cmd;
    logic [ADDR_W-1:0]     w_bits, w_idx;
    logic [15:0]           w_wt;
    logic signed [31:0]    w_grad;
    logic signed [15:0]    w_tval;
    assign w_cmd  = s_axis_tdata[2:0];
    assign w_bits = s_axis_tdata[3 +: ADDR_W];
    assign w_wt   = s_axis_tdata[24:9];
    assign w_grad = s_axis_tdata[56:25];
    assign w_idx  = s_axis_tdata[57 +: ADDR_W];
    assign w_tval = s_axis_tdata[78:63];

    // Memories: value table and the two accumulator stores
    logic signed [VALUE_BITS-1:0] r_vtab [DEPTH];
    logic [ACC_BITS-1:0]          r_hit  [DEPTH];
    logic signed [ACC_BITS-1:0]   r_gacc [DEPTH];
    logic signed [VALUE_BITS-1:0] r_vrd;
    logic [ACC_BITS-1:0]          r_hrd;
    logic signed [ACC_BITS-1:0]   r_grd;

    t_state r_state, n_state;
    logic                r_pe;
    logic [ADDR_W-1:0]   r_addr, r_idx;
    logic signed [VALUE_BITS-1:0] r_held;
    logic [15:0]         r_wt;
    logic signed [31:0]  r_g;
    logic [POS_W-1:0]    r_pos;
    logic [ADDR_W:0]     r_clr;
    logic signed [VALUE_BITS:0]   r_diff;
    logic signed [VALUE_BITS+32:0] r_prod;
    logic signed [31:0]  r_q;
    logic [127:0]        r_out;
    logic                r_ovalid, r_olast;

    // memory access control
    logic                  w_vwe, w_hwe, w_gwe;
    logic [ADDR_W-1:0]     w_vra, w_ara, w_wa;
    logic signed [VALUE_BITS-1:0] w_vwd;
    logic [ACC_BITS-1:0]   w_hwd;
    logic signed [ACC_BITS-1:0] w_gwd;

    logic                  w_take;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_olast;

    // saturated sums (one adder per store)
    logic [ACC_BITS:0]          w_hsum;
    logic signed [ACC_BITS:0]   w_gsum;
    localparam logic signed [ACC_BITS:0] GMAX = {2'b00, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS:0] GMIN = {2'b11, {(ACC_BITS-1){1'b0}}};
    assign w_hsum = {1'b0, r_hrd} + {{(ACC_BITS-16+1){1'b0}}, r_wt};
    assign w_gsum = {r_grd[ACC_BITS-1], r_grd} +
                    {{(ACC_BITS-31){r_g[31]}}, r_g};

    // floor shift by 12 then saturate to 32 bits
    logic signed [VALUE_BITS+20:0] w_sh;
    assign w_sh = (VALUE_BITS+21)'(r_prod >>> 12);

    always_comb begin
        w_vwe = 1'b0; w_hwe = 1'b0; w_gwe = 1'b0;
        w_vra = r_addr; w_ara = r_addr; w_wa = r_addr;
        w_hwd = '0; w_gwd = '0;
        w_vwd = '0;
        unique case (r_state)
            S_IDLE: begin
                w_vra = w_bits; w_ara = w_bits;
                if (w_take && t_cmd'(w_cmd) == CMD_LOAD) begin
                    w_vwe = 1'b1; w_wa = w_idx; w_vwd = VALUE_BITS'(w_tval);
                end
                if (w_take && t_cmd'(w_cmd) == CMD_READ) w_ara = w_idx;
                if (w_take && t_cmd'(w_cmd) == CMD_BWD) w_ara = r_addr;
            end
            S_FWD_WR: begin
                w_hwe = 1'b1; w_wa = r_addr;
                w_hwd = w_hsum[ACC_BITS] ? '1 : w_hsum[ACC_BITS-1:0];
            end
            S_BWD_WR: begin
                w_gwe = 1'b1; w_wa = r_addr;
                w_gwd = (w_gsum > GMAX) ? GMAX[ACC_BITS-1:0] :
                        (w_gsum < GMIN) ? GMIN[ACC_BITS-1:0] : w_gsum[ACC_BITS-1:0];
            end
            S_FLIP_RD: w_vra = r_addr ^ ADDR_W'(1 << r_pos);
            // hold the read address so the accumulators of the index arrive at READ_OUT
            S_READ_RD: w_ara = r_idx;
            S_CLEAR: begin
                w_hwe = 1'b1; w_gwe = 1'b1; w_wa = r_clr[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_vwe) r_vtab[w_wa] <= w_vwd;
        if (w_hwe) r_hit[w_wa]  <= w_hwd;
        if (w_gwe) r_gacc[w_wa] <= w_gwd;
        r_vrd <= r_vtab[w_vra];
        r_hrd <= r_hit[w_ara];
        r_grd <= r_gacc[w_ara];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_take) begin
                unique case (w_cmd)
                    CMD_LOAD:  n_state = S_IDLE;
                    CMD_FWD:   n_state = S_FWD_RD;
                    CMD_BWD:   n_state = S_BWD_RD;
                    CMD_CLEAR: n_state = S_CLEAR;
                    CMD_READ:  n_state = S_READ_RD;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_FWD_RD:  n_state = S_FWD_WR;
            S_FWD_WR:  n_state = S_WAIT;
            S_BWD_RD:  n_state = S_BWD_WR;
            S_BWD_WR:  n_state = S_FLIP_RD;
            S_FLIP_RD: n_state = S_MUL;
            S_MUL:     n_state = S_PROD;
            S_PROD:    n_state = S_SHIFT;
            S_SHIFT:   n_state = S_EMIT;
            S_EMIT:    if (!r_ovalid || m_axis_tready)
                           n_state = (r_pos == POS_W'(NUM_INPUTS-1)) ? S_WAIT : S_FLIP_RD;
            S_CLEAR:   if (r_clr == (ADDR_W+1)'(DEPTH-1)) n_state = S_IDLE;
            S_READ_RD: n_state = S_READ_OUT;
            S_READ_OUT: n_state = S_WAIT;
            S_WAIT:    if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and output register
    logic w_emit, w_read_out, w_fwd_out;
    always_comb begin
        w_emit     = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);
        w_fwd_out  = (r_state == S_FWD_WR);
        w_read_out = (r_state == S_READ_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pe     <= 1'b1;
            r_addr   <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_pe <= i_cfg_wdata;
            // a new word loads the output register, else a taken word empties it
            if (w_fwd_out || w_emit || w_read_out) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            if (w_take) begin
                r_wt <= w_wt; r_g <= w_grad; r_idx <= w_idx; r_pos <= '0;
                if (t_cmd'(w_cmd) == CMD_FWD) r_addr <= w_bits;
                if (t_cmd'(w_cmd) == CMD_CLEAR) r_clr <= '0;
            end
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_FWD_RD) r_held <= r_vrd;
            if (w_fwd_out) begin
                r_out    <= {106'd0, r_addr, r_held};
                r_olast  <= 1'b1;
            end
            if (r_state == S_MUL)
                r_diff <= (VALUE_BITS+1)'(r_vrd) - (VALUE_BITS+1)'(r_held);
            if (r_state == S_SHIFT) begin
                if (!r_pe) r_q <= '0;
                else if (w_sh > 37'sh7FFFFFFF) r_q <= 32'sh7FFFFFFF;
                else if (w_sh < -37'sh80000000) r_q <= 32'sh80000000;
                else r_q <= w_sh[31:0];
            end
            if (w_emit) begin
                r_out    <= {71'd0, r_q, r_pos, 22'd0};
                r_olast  <= (r_pos == POS_W'(NUM_INPUTS-1));
                r_pos    <= r_pos + 1'b1;
            end
            if (w_read_out) begin
                r_out    <= {7'd0, r_grd, r_hrd, 57'd0};
                r_olast  <= 1'b1;
            end
        end
    end

    // multiplier: one registered 32x17 product per input
    always_ff @(posedge i_clk) begin
        if (r_state == S_PROD) r_prod <= r_g * r_diff;
    end
endmodule
